@@ hdl/lsbt_pkg.sv @@
// Shared types and constants for the load/store buffer timing block.
// Used by lsbt_alu, lsbt_tables, load_store_buffer_timing and the dv checker and testbench; no dependencies.
package lsbt_pkg;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned LAT_W  = 32;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Default sizes of the two tables.
  localparam int unsigned LOAD_UNITS_DEF    = 4;
  localparam int unsigned STORE_ENTRIES_DEF = 8;

  // Access kinds.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_STORE = 1'b1;

  // Which table a read or write goes to.
  typedef enum logic {
    TBL_SB = 1'b0,
    TBL_LU = 1'b1
  } tbl_e;

  // Flags of the shared time comparator.
  typedef struct packed {
    logic le_t;  // entry time at or before the request time
    logic ge_t;  // entry time at or after the request time
    logic lt_m;  // entry time below the best time seen so far
  } cmp_t;

endpackage

@@ hdl/load_store_buffer_timing.sv @@
// Top level of the load/store buffer timing block: input capture, scan
// sequencer and output register. Uses lsbt_pkg, lsbt_alu and lsbt_tables.
//
// Usage: one beat on the input channel carries an access (func_i, request_time_i,
// access_addr_i, access_latency_i, l1_hit_i); exactly one beat on the output
// channel answers it, in order (ready_time_o, charged_latency_o, forwarded_o).
// Both channels use valid and stall; a beat moves when valid is high and stall
// is low. The block takes one access at a time and holds in_stall_o high while
// it works on it.
// Scan: the sequencer reads the store entries one per cycle through the
// registered table read port and tests each with the shared time unit, then,
// for a load that is not forwarded, does the same over the load units.
// Scans end early at the first address match or the first free unit.
// The result sits in an output register, so a stalled receiver does not stop
// the next access from being accepted; only a second result waits for it.
// Reset clears every valid bit at once, so all entries read as time zero and
// address zero right after reset; no clearing pass is needed.
module load_store_buffer_timing #(
  parameter int unsigned LOAD_UNITS    = lsbt_pkg::LOAD_UNITS_DEF,
  parameter int unsigned STORE_ENTRIES = lsbt_pkg::STORE_ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [lsbt_pkg::TIME_W-1:0] request_time_i,
  input  logic [lsbt_pkg::ADDR_W-1:0] access_addr_i,
  input  logic [lsbt_pkg::LAT_W-1:0]  access_latency_i,
  input  logic                        l1_hit_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lsbt_pkg::TIME_W-1:0] ready_time_o,
  output logic [lsbt_pkg::LAT_W-1:0]  charged_latency_o,
  output logic                        forwarded_o
);

  localparam int unsigned MAX_N = (STORE_ENTRIES > LOAD_UNITS) ? STORE_ENTRIES : LOAD_UNITS;
  localparam int unsigned CNT_W = $clog2(MAX_N + 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SB_SCAN = 6'b000010,
    S_LU_SCAN = 6'b000100,
    S_DECIDE  = 6'b001000,
    S_WRITE   = 6'b010000,
    S_RESP    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Control registers.
  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic             p_vld_q, p_vld_d;
  logic             match_q, match_d;
  logic             free_fnd_q, free_fnd_d;
  logic             out_valid_q, out_valid_d;

  // Payload registers.
  logic                        func_q, func_d;
  logic [lsbt_pkg::TIME_W-1:0] t_q, t_d;
  logic [lsbt_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [lsbt_pkg::LAT_W-1:0]  lat_q, lat_d;
  logic                        hit_q, hit_d;
  logic [CNT_W-1:0]            p_idx_q, p_idx_d;
  logic [CNT_W-1:0]            match_idx_q, match_idx_d;
  logic                        match_busy_q, match_busy_d;
  logic [CNT_W-1:0]            free_idx_q, free_idx_d;
  logic [CNT_W-1:0]            best_idx_q, best_idx_d;
  logic [lsbt_pkg::TIME_W-1:0] best_val_q, best_val_d;
  logic [CNT_W-1:0]            wr_idx_q, wr_idx_d;
  logic [lsbt_pkg::TIME_W-1:0] base_q, base_d;
  logic [lsbt_pkg::TIME_W-1:0] res_ready_q, res_ready_d;
  logic [lsbt_pkg::LAT_W-1:0]  res_lat_q, res_lat_d;
  logic                        res_fwd_q, res_fwd_d;
  logic [lsbt_pkg::TIME_W-1:0] out_ready_q, out_ready_d;
  logic [lsbt_pkg::LAT_W-1:0]  out_lat_q, out_lat_d;
  logic                        out_fwd_q, out_fwd_d;

  // Table and time unit connections.
  logic                        rd_en;
  lsbt_pkg::tbl_e              rd_sel;
  logic [lsbt_pkg::TIME_W-1:0] rd_time;
  logic [lsbt_pkg::ADDR_W-1:0] rd_addr;
  logic                        wr_en;
  lsbt_pkg::tbl_e              wr_sel;
  logic [lsbt_pkg::TIME_W-1:0] sum;
  lsbt_pkg::cmp_t              cmp;

  logic [CNT_W-1:0] limit;
  logic             in_acc;
  logic             out_acc;

  lsbt_tables #(
    .LOAD_UNITS   (LOAD_UNITS),
    .STORE_ENTRIES(STORE_ENTRIES)
  ) u_tables (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_sel_i (rd_sel),
    .rd_idx_i (rd_cnt_q),
    .rd_time_o(rd_time),
    .rd_addr_o(rd_addr),
    .wr_en_i  (wr_en),
    .wr_sel_i (wr_sel),
    .wr_idx_i (wr_idx_q),
    .wr_time_i(sum),
    .wr_addr_i(addr_q)
  );

  lsbt_alu u_alu (
    .entry_time_i(rd_time),
    .req_time_i  (t_q),
    .best_time_i (best_val_q),
    .base_time_i (base_q),
    .lat_i       (lat_q),
    .cmp_o       (cmp),
    .sum_o       (sum)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign rd_sel     = (state_q == S_LU_SCAN) ? lsbt_pkg::TBL_LU : lsbt_pkg::TBL_SB;
  assign wr_sel     = (func_q == lsbt_pkg::FUNC_STORE) ? lsbt_pkg::TBL_SB : lsbt_pkg::TBL_LU;
  assign limit      = (state_q == S_LU_SCAN) ? CNT_W'(LOAD_UNITS) : CNT_W'(STORE_ENTRIES);

  // Sequencer: scan the store entries, then for a load the load units; update one slot unless a load is forwarded.
  always_comb begin
    logic stop;
    logic done;
    state_d      = state_q;
    rd_cnt_d     = rd_cnt_q;
    p_vld_d      = p_vld_q;
    p_idx_d      = p_idx_q;
    match_d      = match_q;
    match_idx_d  = match_idx_q;
    match_busy_d = match_busy_q;
    free_fnd_d   = free_fnd_q;
    free_idx_d   = free_idx_q;
    best_idx_d   = best_idx_q;
    best_val_d   = best_val_q;
    wr_idx_d     = wr_idx_q;
    base_d       = base_q;
    res_ready_d  = res_ready_q;
    res_lat_d    = res_lat_q;
    res_fwd_d    = res_fwd_q;
    func_d       = func_q;
    t_d          = t_q;
    addr_d       = addr_q;
    lat_d        = lat_q;
    hit_d        = hit_q;
    out_ready_d  = out_ready_q;
    out_lat_d    = out_lat_q;
    out_fwd_d    = out_fwd_q;
    out_valid_d  = out_valid_q && out_stall_i;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    stop         = 1'b0;
    done         = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          func_d     = func_i;
          t_d        = request_time_i;
          addr_d     = access_addr_i;
          lat_d      = access_latency_i;
          hit_d      = l1_hit_i;
          match_d    = 1'b0;
          free_fnd_d = 1'b0;
          rd_cnt_d   = '0;
          p_vld_d    = 1'b0;
          state_d    = S_SB_SCAN;
        end
      end

      S_SB_SCAN, S_LU_SCAN: begin
        // Issue the read of the next entry.
        if (rd_cnt_q < limit) begin
          rd_en    = 1'b1;
          rd_cnt_d = rd_cnt_q + CNT_W'(1);
          p_vld_d  = 1'b1;
          p_idx_d  = rd_cnt_q;
        end else begin
          p_vld_d = 1'b0;
        end

        // Test the entry whose data came back this cycle.
        if (p_vld_q) begin
          if (state_q == S_SB_SCAN && rd_addr == addr_q) begin
            match_d      = 1'b1;
            match_idx_d  = p_idx_q;
            match_busy_d = cmp.ge_t;
            stop         = 1'b1;
          end else begin
            if (!free_fnd_q && cmp.le_t) begin
              free_fnd_d = 1'b1;
              free_idx_d = p_idx_q;
              if (state_q == S_LU_SCAN) begin
                stop = 1'b1;
              end
            end
            if (p_idx_q == '0 || cmp.lt_m) begin
              best_idx_d = p_idx_q;
              best_val_d = rd_time;
            end
          end
          done = stop || (p_idx_q == limit - CNT_W'(1));
        end

        // End of a scan.
        if (done) begin
          p_vld_d  = 1'b0;
          rd_cnt_d = '0;
          if (state_q == S_LU_SCAN || func_q == lsbt_pkg::FUNC_STORE) begin
            state_d = S_DECIDE;
          end else if (match_d && (match_busy_d || hit_q)) begin
            res_ready_d = t_q;
            res_lat_d   = '0;
            res_fwd_d   = 1'b1;
            state_d     = S_RESP;
          end else begin
            free_fnd_d = 1'b0;
            state_d    = S_LU_SCAN;
          end
        end
      end

      S_DECIDE: begin
        // Pick the slot to update and the time its occupancy starts from.
        if (func_q == lsbt_pkg::FUNC_STORE && match_q) begin
          wr_idx_d    = match_idx_q;
          base_d      = t_q;
          res_ready_d = t_q;
        end else if (free_fnd_q) begin
          wr_idx_d    = free_idx_q;
          base_d      = t_q;
          res_ready_d = t_q;
        end else begin
          wr_idx_d    = best_idx_q;
          base_d      = best_val_q;
          res_ready_d = best_val_q;
        end
        state_d = S_WRITE;
      end

      S_WRITE: begin
        wr_en     = 1'b1;
        res_lat_d = (func_q == lsbt_pkg::FUNC_STORE) ? '0 : lat_q;
        res_fwd_d = 1'b0;
        state_d   = S_RESP;
      end

      S_RESP: begin
        // Move the result into the output register once it is free.
        if (!out_valid_q || out_acc) begin
          out_ready_d = res_ready_q;
          out_lat_d   = res_lat_q;
          out_fwd_d   = res_fwd_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_cnt_q    <= '0;
      p_vld_q     <= 1'b0;
      match_q     <= 1'b0;
      free_fnd_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      p_vld_q     <= p_vld_d;
      match_q     <= match_d;
      free_fnd_q  <= free_fnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and scan trackers.
  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    t_q          <= t_d;
    addr_q       <= addr_d;
    lat_q        <= lat_d;
    hit_q        <= hit_d;
    p_idx_q      <= p_idx_d;
    match_idx_q  <= match_idx_d;
    match_busy_q <= match_busy_d;
    free_idx_q   <= free_idx_d;
    best_idx_q   <= best_idx_d;
    best_val_q   <= best_val_d;
    wr_idx_q     <= wr_idx_d;
    base_q       <= base_d;
    res_ready_q  <= res_ready_d;
    res_lat_q    <= res_lat_d;
    res_fwd_q    <= res_fwd_d;
    out_ready_q  <= out_ready_d;
    out_lat_q    <= out_lat_d;
    out_fwd_q    <= out_fwd_d;
  end

  assign out_valid_o       = out_valid_q;
  assign ready_time_o      = out_ready_q;
  assign charged_latency_o = out_lat_q;
  assign forwarded_o       = out_fwd_q;

  // The entry under test always lies inside the table being scanned.
  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q |-> (p_idx_q < limit))
    else $error("scan index beyond table size");

  // An access never proceeds before it was issued.
  a_ready_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) |-> (res_ready_q >= t_q))
    else $error("ready time before request time");

  // With no free slot, the earliest slot must still be busy past the request.
  a_best_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DECIDE) && !free_fnd_q &&
     !(func_q == lsbt_pkg::FUNC_STORE && match_q)) |-> (best_val_q > t_q))
    else $error("earliest slot not busy although no slot was free");

endmodule

@@ hdl/lsbt_alu.sv @@
// Shared time unit: compares an entry's free time against the request time
// and the running minimum, and forms the saturating occupancy sum. Uses lsbt_pkg.
module lsbt_alu (
  input  logic [lsbt_pkg::TIME_W-1:0] entry_time_i,
  input  logic [lsbt_pkg::TIME_W-1:0] req_time_i,
  input  logic [lsbt_pkg::TIME_W-1:0] best_time_i,
  input  logic [lsbt_pkg::TIME_W-1:0] base_time_i,
  input  logic [lsbt_pkg::LAT_W-1:0]  lat_i,
  output lsbt_pkg::cmp_t              cmp_o,
  output logic [lsbt_pkg::TIME_W-1:0] sum_o
);

  logic [lsbt_pkg::TIME_W:0] diff_t;
  logic [lsbt_pkg::TIME_W:0] diff_m;
  logic [lsbt_pkg::TIME_W:0] sum_full;
  logic                      eq_t;

  // A borrow out of the top bit means the entry time is the smaller one.
  assign diff_t = {1'b0, entry_time_i} - {1'b0, req_time_i};
  assign diff_m = {1'b0, entry_time_i} - {1'b0, best_time_i};
  assign eq_t   = (diff_t[lsbt_pkg::TIME_W-1:0] == '0);

  assign cmp_o.le_t = diff_t[lsbt_pkg::TIME_W] | eq_t;
  assign cmp_o.ge_t = ~diff_t[lsbt_pkg::TIME_W];
  assign cmp_o.lt_m = diff_m[lsbt_pkg::TIME_W];

  // A carry into bit 48 means the sum passed the largest time.
  assign sum_full = {1'b0, base_time_i}
                  + {{(lsbt_pkg::TIME_W + 1 - lsbt_pkg::LAT_W){1'b0}}, lat_i};
  assign sum_o    = sum_full[lsbt_pkg::TIME_W] ? lsbt_pkg::TIME_MAX
                                               : sum_full[lsbt_pkg::TIME_W-1:0];

endmodule

@@ hdl/lsbt_tables.sv @@
// Store buffer entries (address and free time) and load unit free times,
// with one registered read port and one write port. Uses lsbt_pkg.
module lsbt_tables #(
  parameter int unsigned LOAD_UNITS    = lsbt_pkg::LOAD_UNITS_DEF,
  parameter int unsigned STORE_ENTRIES = lsbt_pkg::STORE_ENTRIES_DEF,
  localparam int unsigned MAX_N = (STORE_ENTRIES > LOAD_UNITS) ? STORE_ENTRIES : LOAD_UNITS,
  localparam int unsigned CNT_W = $clog2(MAX_N + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rd_en_i,
  input  lsbt_pkg::tbl_e                      rd_sel_i,
  input  logic [CNT_W-1:0]                    rd_idx_i,
  output logic [lsbt_pkg::TIME_W-1:0]         rd_time_o,
  output logic [lsbt_pkg::ADDR_W-1:0]         rd_addr_o,
  input  logic                                wr_en_i,
  input  lsbt_pkg::tbl_e                      wr_sel_i,
  input  logic [CNT_W-1:0]                    wr_idx_i,
  input  logic [lsbt_pkg::TIME_W-1:0]         wr_time_i,
  input  logic [lsbt_pkg::ADDR_W-1:0]         wr_addr_i
);

  localparam int unsigned SE_W  = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1;
  localparam int unsigned LU_W  = (LOAD_UNITS > 1) ? $clog2(LOAD_UNITS) : 1;

  logic [lsbt_pkg::TIME_W-1:0] sb_time_q [STORE_ENTRIES];
  logic [lsbt_pkg::ADDR_W-1:0] sb_addr_q [STORE_ENTRIES];
  logic [STORE_ENTRIES-1:0]    sb_vld_q;
  logic [lsbt_pkg::TIME_W-1:0] lu_time_q [LOAD_UNITS];
  logic [LOAD_UNITS-1:0]       lu_vld_q;

  logic [lsbt_pkg::TIME_W-1:0] rd_time_q;
  logic [lsbt_pkg::ADDR_W-1:0] rd_addr_q;

  logic [SE_W-1:0] rd_se_idx;
  logic [LU_W-1:0] rd_lu_idx;
  logic [SE_W-1:0] wr_se_idx;
  logic [LU_W-1:0] wr_lu_idx;

  assign rd_se_idx = rd_idx_i[SE_W-1:0];
  assign rd_lu_idx = rd_idx_i[LU_W-1:0];
  assign wr_se_idx = wr_idx_i[SE_W-1:0];
  assign wr_lu_idx = wr_idx_i[LU_W-1:0];

  // Valid bits: an entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_vld_q <= '0;
      lu_vld_q <= '0;
    end else if (wr_en_i) begin
      if (wr_sel_i == lsbt_pkg::TBL_SB) begin
        sb_vld_q[wr_se_idx] <= 1'b1;
      end else begin
        lu_vld_q[wr_lu_idx] <= 1'b1;
      end
    end
  end

  // Table write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      if (wr_sel_i == lsbt_pkg::TBL_SB) begin
        sb_time_q[wr_se_idx] <= wr_time_i;
        sb_addr_q[wr_se_idx] <= wr_addr_i;
      end else begin
        lu_time_q[wr_lu_idx] <= wr_time_i;
      end
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (rd_sel_i == lsbt_pkg::TBL_SB) begin
        rd_time_q <= sb_vld_q[rd_se_idx] ? sb_time_q[rd_se_idx] : '0;
        rd_addr_q <= sb_vld_q[rd_se_idx] ? sb_addr_q[rd_se_idx] : '0;
      end else begin
        rd_time_q <= lu_vld_q[rd_lu_idx] ? lu_time_q[rd_lu_idx] : '0;
        rd_addr_q <= '0;
      end
    end
  end

  assign rd_time_o = rd_time_q;
  assign rd_addr_o = rd_addr_q;

endmodule

@@ dv/lsbt_timing_checker.sv @@
`timescale 1ns / 100ps
// Checker for the load/store buffer timing block: keeps its own copy of the
// store entry and load unit tables and compares each output beat. Uses lsbt_pkg.
module lsbt_timing_checker
  import lsbt_pkg::*;
#(
  parameter int unsigned LOAD_UNITS    = LOAD_UNITS_DEF,
  parameter int unsigned STORE_ENTRIES = STORE_ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              func_i,
  input  logic [TIME_W-1:0] request_time_i,
  input  logic [ADDR_W-1:0] access_addr_i,
  input  logic [LAT_W-1:0]  access_latency_i,
  input  logic              l1_hit_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [TIME_W-1:0] ready_time_i,
  input  logic [LAT_W-1:0]  charged_latency_i,
  input  logic              forwarded_i,
  output int                mismatch_count_o,
  output int                replies_due_o
);

  typedef struct packed {
    logic [TIME_W-1:0] ready_time;
    logic [LAT_W-1:0]  charged_latency;
    logic              forwarded;
  } reply_t;

  // Shadow copy of the timing tables.
  logic [TIME_W-1:0] unit_free_at  [LOAD_UNITS];
  logic [TIME_W-1:0] entry_free_at [STORE_ENTRIES];
  logic [ADDR_W-1:0] entry_addr    [STORE_ENTRIES];

  reply_t due_replies [$];
  int     mismatches = 0;
  int     due_count  = 0;

  assign mismatch_count_o = mismatches;
  assign replies_due_o    = due_count;

  // Time plus latency, clipped at the largest representable time.
  function automatic logic [TIME_W-1:0] sat_sum(input logic [TIME_W-1:0] t,
                                                input logic [LAT_W-1:0] lat);
    logic [TIME_W:0] s;
    s = {1'b0, t} + {{(TIME_W+1-LAT_W){1'b0}}, lat};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  // Earliest-free placement on one table. The lowest free slot is taken;
  // when none is free, the slot that frees first is extended and its old
  // free time is the ready time.
  function automatic int claim_slot(input tbl_e tbl, input logic [TIME_W-1:0] t,
                                    input logic [LAT_W-1:0] lat,
                                    output logic [TIME_W-1:0] ready);
    int n;
    int i;
    int slot;
    int best;
    logic [TIME_W-1:0] ft;
    logic [TIME_W-1:0] best_ft;
    logic [TIME_W-1:0] upd;
    n = (tbl == TBL_SB) ? STORE_ENTRIES : LOAD_UNITS;
    slot = -1;
    best = 0;
    best_ft = (tbl == TBL_SB) ? entry_free_at[0] : unit_free_at[0];
    for (i = 0; i < n; i++) begin
      if (tbl == TBL_SB) ft = entry_free_at[i];
      else ft = unit_free_at[i];
      if (slot < 0 && ft <= t) slot = i;
      if (ft < best_ft) begin
        best = i;
        best_ft = ft;
      end
    end
    if (slot >= 0) begin
      ready = t;
      upd = sat_sum(t, lat);
    end else begin
      slot = best;
      ready = best_ft;
      upd = sat_sum(best_ft, lat);
    end
    if (tbl == TBL_SB) entry_free_at[slot] = upd;
    else unit_free_at[slot] = upd;
    return slot;
  endfunction

  // Works out the reply to one access and updates the shadow tables.
  function automatic reply_t predict_access(input logic fn, input logic [TIME_W-1:0] t,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [LAT_W-1:0] lat, input logic hit);
    reply_t r;
    int match;
    int slot;
    int i;
    logic [TIME_W-1:0] ready;
    match = -1;
    for (i = STORE_ENTRIES - 1; i >= 0; i--) begin
      if (entry_addr[i] == addr) match = i;
    end
    r = '0;
    if (fn == FUNC_STORE) begin
      if (match >= 0) begin
        entry_free_at[match] = sat_sum(t, lat);
        r.ready_time = t;
      end else begin
        slot = claim_slot(TBL_SB, t, lat, ready);
        entry_addr[slot] = addr;
        r.ready_time = ready;
      end
    end else if (match >= 0 && (entry_free_at[match] >= t || hit)) begin
      // The store buffer still holds the data, or it completed and L1 has it.
      r.ready_time = t;
      r.forwarded = 1'b1;
    end else begin
      slot = claim_slot(TBL_LU, t, lat, ready);
      r.ready_time = ready;
      r.charged_latency = lat;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Output beats are compared before the input beat of the same edge is
  // predicted, since a reply can never belong to an access taken that edge.
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      foreach (unit_free_at[i]) unit_free_at[i] = '0;
      foreach (entry_free_at[i]) begin
        entry_free_at[i] = '0;
        entry_addr[i] = '0;
      end
      due_replies.delete();
      due_count = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_replies.size() == 0) begin
          $error("reply beat with no access outstanding: ready_time %0h", ready_time_i);
          mismatches++;
        end else begin
          want = due_replies.pop_front();
          check_field("ready_time", want.ready_time, ready_time_i);
          check_field("charged_latency", want.charged_latency, charged_latency_i);
          check_field("forwarded", want.forwarded, forwarded_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        due_replies.push_back(predict_access(func_i, request_time_i, access_addr_i,
                                             access_latency_i, l1_hit_i));
      end
      due_count = due_replies.size();
    end
  end

endmodule

@@ dv/load_store_buffer_timing_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the load/store buffer timing block: clock, reset, access
// stimulus and receiver stalls. Uses lsbt_pkg and lsbt_timing_checker.
module load_store_buffer_timing_tb;
  import lsbt_pkg::*;

  localparam int RANDOM_ACCESSES = 900;
  localparam int POOL_SIZE       = 12;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 40;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              func = FUNC_LOAD;
  logic [TIME_W-1:0] request_time = '0;
  logic [ADDR_W-1:0] access_addr = '0;
  logic [LAT_W-1:0]  access_latency = '0;
  logic              l1_hit = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [TIME_W-1:0] ready_time;
  logic [LAT_W-1:0]  charged_latency;
  logic              forwarded;

  int mismatch_count;
  int replies_due;
  int idle_cycles = 0;
  int stall_hold = 0;
  bit quiet = 1'b0;

  load_store_buffer_timing u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .func_i           (func),
    .request_time_i   (request_time),
    .access_addr_i    (access_addr),
    .access_latency_i (access_latency),
    .l1_hit_i         (l1_hit),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .ready_time_o     (ready_time),
    .charged_latency_o(charged_latency),
    .forwarded_o      (forwarded)
  );

  lsbt_timing_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .func_i           (func),
    .request_time_i   (request_time),
    .access_addr_i    (access_addr),
    .access_latency_i (access_latency),
    .l1_hit_i         (l1_hit),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .ready_time_i     (ready_time),
    .charged_latency_i(charged_latency),
    .forwarded_i      (forwarded),
    .mismatch_count_o (mismatch_count),
    .replies_due_o    (replies_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long; none in quiet phases.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Receiver side: random runs of ready and stalled cycles; no new stall starts in quiet phases.
  always @(negedge clk) begin
    if (stall_hold == 0) begin
      if (quiet || $urandom_range(0, 1) == 0) begin
        out_stall <= 1'b0;
        stall_hold <= $urandom_range(1, 8);
      end else begin
        out_stall <= 1'b1;
        stall_hold <= pick_gap();
      end
    end else begin
      stall_hold <= stall_hold - 1;
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Presents one access after a random gap and holds it until accepted.
  task automatic issue_access(input logic fn, input logic [TIME_W-1:0] t,
                              input logic [ADDR_W-1:0] addr,
                              input logic [LAT_W-1:0] lat, input logic hit);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    request_time <= t;
    access_addr <= addr;
    access_latency <= lat;
    l1_hit <= hit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] base_time;
    logic [TIME_W-1:0] t;
    logic [LAT_W-1:0]  lat;
    int r;
    int n;

    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (n = 2; n < POOL_SIZE; n++) addr_pool[n] = {$urandom, $urandom};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Right after reset every entry holds address zero.
    issue_access(FUNC_LOAD, 48'd0, addr_pool[0], 32'd5, 1'b0);   // busy at time zero
    issue_access(FUNC_LOAD, 48'd1, addr_pool[0], 32'd7, 1'b0);   // completed, L1 miss
    issue_access(FUNC_LOAD, 48'd1, addr_pool[0], 32'd0, 1'b1);   // completed, L1 hit
    issue_access(FUNC_STORE, 48'd2, addr_pool[0], 32'd10, 1'b0); // re-arms entry 0
    issue_access(FUNC_LOAD, 48'd12, addr_pool[0], 32'd0, 1'b0);  // free time equals request
    issue_access(FUNC_LOAD, 48'd13, addr_pool[0], 32'd0, 1'b0);  // completed, L1 miss
    issue_access(FUNC_LOAD, 48'd13, addr_pool[1], 32'd3, 1'b1);  // miss with L1 hit
    // Fill the store buffer, leaving one entry with address zero.
    for (n = 1; n < 8; n++) issue_access(FUNC_STORE, 48'd14, addr_pool[n], 32'd100, 1'b0);
    issue_access(FUNC_STORE, 48'd15, addr_pool[0], 32'd1, 1'b0);
    // Nothing free: the earliest entry is extended by the largest latency.
    issue_access(FUNC_STORE, 48'd15, addr_pool[8], '1, 1'b0);
    issue_access(FUNC_STORE, TIME_MAX, addr_pool[9], '1, 1'b0);  // saturates
    issue_access(FUNC_STORE, 48'd20, addr_pool[9], 32'd0, 1'b0);
    // Occupy all load units, then one more load waits for the earliest.
    for (n = 0; n < 4; n++) issue_access(FUNC_LOAD, 48'd20, {$urandom, $urandom}, 32'd30, 1'b0);
    issue_access(FUNC_LOAD, 48'd21, {$urandom, $urandom}, 32'd5, 1'b0);
    issue_access(FUNC_LOAD, TIME_MAX, addr_pool[9], '1, 1'b1);
    issue_access(FUNC_LOAD, 48'd22, addr_pool[3], '1, 1'b0);

    // Random part over a small address pool so entries are hit often.
    base_time = 48'd30;
    for (n = 0; n < RANDOM_ACCESSES; n++) begin
      if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      // The last accesses run close to the largest time to exercise clipping.
      if (n == RANDOM_ACCESSES - 30) base_time = TIME_MAX - $urandom_range(0, 500);
      if (base_time < TIME_MAX - 48'd20) base_time += $urandom_range(0, 6);
      if (n < RANDOM_ACCESSES - 30 && $urandom_range(0, 49) == 0) base_time += $urandom;

      r = $urandom_range(0, 99);
      t = base_time;
      if (r < 10) t = (base_time > 48'd30) ? base_time - $urandom_range(0, 30) : '0;
      else if (r < 15 && base_time < TIME_MAX - 48'd20) t = base_time + $urandom_range(1, 20);

      r = $urandom_range(0, 99);
      if (r < 3) addr_pool[$urandom_range(2, POOL_SIZE - 1)] = {$urandom, $urandom};
      if (r < 10) addr = {$urandom, $urandom};
      else addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];

      r = $urandom_range(0, 99);
      if (r < 10) lat = $urandom_range(0, 3);
      else if (r < 85) lat = $urandom_range(0, 40);
      else if (r < 95) lat = $urandom_range(100, 5000);
      else lat = $urandom;

      issue_access($urandom_range(0, 1) ? FUNC_STORE : FUNC_LOAD, t, addr, lat,
                   1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (replies_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && replies_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/lsbt_pkg.sv
hdl/lsbt_alu.sv
hdl/lsbt_tables.sv
hdl/load_store_buffer_timing.sv
dv/lsbt_timing_checker.sv
dv/load_store_buffer_timing_tb.sv
